// File: rtl/core/rc_pkg.sv
// ----------------------------------------------------------------------------
// rc_pkg
// Shared types, codes and helpers for the radix converter.
// ----------------------------------------------------------------------------
package rc_pkg;

    localparam int DIGIT_W = 6;   // width of a digit value and of a base
    localparam int CHAR_W  = 8;

    // Result status; the numeric order is also the error priority
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BASE = 2'd1,
        ST_CHAR = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic REG_SOURCE_BASE = 1'b0;
    localparam logic REG_TARGET_BASE = 1'b1;

    localparam logic [DIGIT_W-1:0] SRC_BASE_RST = 6'd10;
    localparam logic [DIGIT_W-1:0] TGT_BASE_RST = 6'd2;
    localparam logic [DIGIT_W-1:0] TGT_BASE_MIN = 6'd2;
    localparam logic [DIGIT_W-1:0] TGT_BASE_MAX = 6'd36;

    localparam logic [CHAR_W-1:0] ASCII_0    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_9    = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_A    = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LZ   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP   = 8'd32;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

    // Queue handshake status seen by both sides
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

    // Digit value (below 36) to its ASCII code
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] r);
        logic [CHAR_W-1:0] rw;
        rw = {2'b00, r};
        if (rw < LETTER_OFS)
            return ASCII_0 + rw;
        else
            return ASCII_A + (rw - LETTER_OFS);
    endfunction

endpackage

// File: rtl/core/rc_front.sv
// ----------------------------------------------------------------------------
// rc_front
// Character front end: case folding, digit decode, base check and
// accumulation with overflow detection. Pushes one job per number.
// ----------------------------------------------------------------------------
module rc_front
    import rc_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_tvalid,
    output logic                    in_tready,
    input  logic [CHAR_W-1:0]       in_tdata,
    input  logic                    in_tlast,
    input  logic [DIGIT_W-1:0]      src_base,
    input  q_stat_t                 q_stat,
    output logic                    push,
    output logic [VALUE_BITS+1:0]   push_data
);

    localparam int PW = VALUE_BITS + DIGIT_W;

    logic [VALUE_BITS-1:0] acc_reg, acc_next, acc_upd;
    status_t               err_reg, err_next, err_upd;

    logic [CHAR_W-1:0]  ch;
    logic               is_digit;
    logic [DIGIT_W-1:0] d;
    logic [PW-1:0]      prod;
    status_t            code_new;
    logic               accept;

    assign in_tready = !q_stat.full;
    assign accept    = in_tvalid && in_tready;

    always_comb
    begin
        ch       = in_tdata;
        is_digit = 1'b1;
        d        = '0;
        if (ch inside {[ASCII_LA:ASCII_LZ]})
            ch = ch - CASE_GAP;
        if (ch inside {[ASCII_0:ASCII_9]})
            d = DIGIT_W'(ch - ASCII_0);
        else if (ch inside {[ASCII_A:ASCII_Z]})
            d = DIGIT_W'(ch - ASCII_A + LETTER_OFS);
        else
            is_digit = 1'b0;

        prod = ({{DIGIT_W{1'b0}}, acc_reg} * {{VALUE_BITS{1'b0}}, src_base})
             + {{VALUE_BITS{1'b0}}, d};

        acc_upd  = acc_reg;
        code_new = ST_OK;
        if (!is_digit)
            code_new = ST_CHAR;
        else if (d >= src_base)
            code_new = ST_BASE;
        else if (err_reg == ST_OK)
        begin
            if (|prod[PW-1:VALUE_BITS])
                code_new = ST_OVF;
            else
                acc_upd = prod[VALUE_BITS-1:0];
        end

        // smallest nonzero code wins
        err_upd = err_reg;
        if (code_new != ST_OK && (err_reg == ST_OK || code_new < err_reg))
            err_upd = code_new;

        acc_next = acc_reg;
        err_next = err_reg;
        if (accept)
        begin
            if (in_tlast)
            begin
                acc_next = '0;
                err_next = ST_OK;
            end
            else
            begin
                acc_next = acc_upd;
                err_next = err_upd;
            end
        end
    end

    assign push      = accept && in_tlast;
    assign push_data = {err_upd, acc_upd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            err_reg <= ST_OK;
        end
        else
        begin
            acc_reg <= acc_next;
            err_reg <= err_next;
        end
    end

endmodule

// File: rtl/core/rc_queue.sv
// ----------------------------------------------------------------------------
// rc_queue
// Two-entry job queue between the character front end and the converter.
// ----------------------------------------------------------------------------
module rc_queue
    import rc_pkg::*;
#(
    parameter int W = 34
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output q_stat_t      q_stat
);

    logic [W-1:0] mem [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign q_stat.not_empty = (count_reg != 2'd0);
    assign q_stat.full      = (count_reg == 2'd2);
    assign do_push          = push && !q_stat.full;
    assign do_pop           = pop && q_stat.not_empty;
    assign pop_data         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/rc_back.sv
// ----------------------------------------------------------------------------
// rc_back
// Converter back end: repeated division by the target base, eight
// quotient bits per cycle, and the registered result stage.
// ----------------------------------------------------------------------------
module rc_back
    import rc_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [DIGIT_W-1:0]    tgt_base,
    input  q_stat_t               q_stat,
    input  logic [VALUE_BITS+1:0] pop_data,
    output logic                  pop,
    output logic                  out_tvalid,
    input  logic                  out_tready,
    output logic [CHAR_W-1:0]     out_tdata,
    output logic                  out_tlast,
    output logic [1:0]            out_tuser
);

    localparam int STEPS = (VALUE_BITS + 7) / 8;
    localparam int DIV_W = STEPS * 8;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [DIV_W-1:0]   work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    status_t            err_reg, err_next;
    logic               ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]  odata_reg, odata_next;
    logic               olast_reg, olast_next;
    status_t            ouser_reg, ouser_next;

    logic [7:0]         qbits;
    logic [DIGIT_W-1:0] rem_div;
    logic               out_free;
    status_t            job_err;

    assign out_free = !ovalid_reg || out_tready;
    assign pop      = (state_reg == S_IDLE) && q_stat.not_empty;
    assign job_err  = status_t'(pop_data[VALUE_BITS+1:VALUE_BITS]);

    // one byte of restoring division; remainder stays below the base
    always_comb
    begin
        logic [DIGIT_W:0] t;
        rem_div = rem_reg;
        qbits   = '0;
        for (int i = 7; i >= 0; i--)
        begin
            t = {rem_div, work_reg[DIV_W-8+i]};
            if (t >= {1'b0, tgt_base})
            begin
                t        = t - {1'b0, tgt_base};
                qbits[i] = 1'b1;
            end
            rem_div = t[DIGIT_W-1:0];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        work_next   = work_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        ouser_next  = ouser_reg;
        ovalid_next = ovalid_reg && !out_tready;

        case (state_reg)
            S_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    work_next = DIV_W'(pop_data[VALUE_BITS-1:0]);
                    rem_next  = '0;
                    cnt_next  = '0;
                    err_next  = job_err;
                    state_next = (job_err != ST_OK) ? S_EMIT : S_DIV;
                end
            end
            S_DIV:
            begin
                work_next = (work_reg << 8) | DIV_W'(qbits);
                rem_next  = rem_div;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    if (err_reg != ST_OK)
                    begin
                        odata_next = '0;
                        olast_next = 1'b1;
                        ouser_next = err_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        odata_next = digit_ascii(rem_reg);
                        olast_next = (work_reg == '0);
                        ouser_next = ST_OK;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = (work_reg == '0) ? S_IDLE : S_DIV;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            work_reg   <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            err_reg    <= ST_OK;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
            olast_reg  <= 1'b0;
            ouser_reg  <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            work_reg   <= work_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
            odata_reg  <= odata_next;
            olast_reg  <= olast_next;
            ouser_reg  <= ouser_next;
        end
    end

    assign out_tvalid = ovalid_reg;
    assign out_tdata  = odata_reg;
    assign out_tlast  = olast_reg;
    assign out_tuser  = ouser_reg;

endmodule

// File: rtl/core/radix_converter.sv
// ----------------------------------------------------------------------------
// radix_converter
// Converts ASCII numbers between bases 2 and 36.
// ----------------------------------------------------------------------------
// Characters arrive most significant first, one per request, and are taken
// one per cycle while the two-entry job queue has room; the request with
// tlast closes the number. The converter then produces the digits in the
// target base, least significant first, with tlast on the most significant
// digit. For each digit the divider retires eight quotient bits a cycle
// over the whole value, then the emit state loads the result register once
// the output is free. An error result is a single zero code with tlast set
// and the error in tuser. Write the base registers only while the block is
// idle; a target base outside 2..36 is clamped on write.
module radix_converter
    import rc_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [DIGIT_W-1:0] cfg_data,
    // character stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  logic               s_axis_tlast,   // final_char
    // digit stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CHAR_W-1:0]  m_axis_tdata,   // [7:0] digit_code
    output logic               m_axis_tlast,   // end_of_run
    output logic [1:0]         m_axis_tuser    // [1:0] status
);

    logic [DIGIT_W-1:0]    src_base_reg, src_base_next;
    logic [DIGIT_W-1:0]    tgt_base_reg, tgt_base_next;
    q_stat_t               q_stat;
    logic                  push, pop;
    logic [VALUE_BITS+1:0] push_data, pop_data;

    always_comb
    begin
        src_base_next = src_base_reg;
        tgt_base_next = tgt_base_reg;
        if (cfg_we)
        begin
            if (cfg_index == REG_SOURCE_BASE)
                src_base_next = cfg_data;
            else if (cfg_data < TGT_BASE_MIN)
                tgt_base_next = TGT_BASE_MIN;
            else if (cfg_data > TGT_BASE_MAX)
                tgt_base_next = TGT_BASE_MAX;
            else
                tgt_base_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_base_reg <= SRC_BASE_RST;
            tgt_base_reg <= TGT_BASE_RST;
        end
        else
        begin
            src_base_reg <= src_base_next;
            tgt_base_reg <= tgt_base_next;
        end
    end

    rc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .in_tdata  (s_axis_tdata),
        .in_tlast  (s_axis_tlast),
        .src_base  (src_base_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    rc_queue #(.W(VALUE_BITS + 2)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    rc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .tgt_base   (tgt_base_reg),
        .q_stat     (q_stat),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .out_tlast  (m_axis_tlast),
        .out_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // error results are a lone zero code closing the run
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("error result without tlast or with nonzero code");

    // good digits are always 0-9 or A-Z
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OK) |->
        ((m_axis_tdata >= ASCII_0 && m_axis_tdata <= ASCII_9) ||
         (m_axis_tdata >= ASCII_A && m_axis_tdata <= ASCII_Z)))
        else $error("output digit outside 0-9/A-Z");

    // divider never sees a target base outside 2..36
    a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tgt_base_reg >= TGT_BASE_MIN && tgt_base_reg <= TGT_BASE_MAX))
        else $error("target base out of range");
`endif

endmodule

// File: sim/radix_converter_test.sv
// ----------------------------------------------------------------------------
// radix_converter_test
// Self-checking bench for the radix converter.
// ----------------------------------------------------------------------------
// A directed table walks the corner cases first: zero, the largest 32-bit
// value, lowercase folding, each error status and its priority, and base
// settings outside 2..36. Numbers with random digits under random base
// settings follow. Each digit is checked against a local conversion model
// or, in checked rows, the typed result. Requests arrive in bursts and the
// digit side stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module radix_converter_test;
    import rc_pkg::*;

    localparam int VALUE_BITS     = 32;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int DIRECTED_ROWS  = 30;
    localparam int RANDOM_CHARS   = 406;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              eor;
        status_t           status;
    } digit_res_t;

    typedef enum logic {
        ROW_CFG,
        ROW_CHAR
    } row_kind_t;

    // chk set: the result is the one typed into the row
    typedef struct packed {
        row_kind_t         kind;
        logic              idx;
        logic [CHAR_W-1:0] val;
        logic              lst;
        logic              chk;
        logic [CHAR_W-1:0] x_code;
        logic              x_eor;
        status_t           x_status;
    } step_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [DIGIT_W-1:0] cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [CHAR_W-1:0]  s_axis_tdata;    // [7:0] char_code
    logic               s_axis_tlast;    // final_char
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [CHAR_W-1:0]  m_axis_tdata;    // [7:0] digit_code
    logic               m_axis_tlast;    // end_of_run
    logic [1:0]         m_axis_tuser;    // [1:0] status

    // conversion model state
    logic [63:0]        value_acc;
    status_t            fault_seen;
    logic [DIGIT_W-1:0] src_radix;
    logic [DIGIT_W-1:0] dst_radix;

    digit_res_t pending_digits[$];
    step_row_t  directed_rows [DIRECTED_ROWS];
    int         mismatches = 0;
    int         burst_left = 0;
    int         quiet_cycles = 0;
    int         random_sent = 0;
    bit         hold_off_req = 1'b0;

    radix_converter #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // lowest nonzero code wins
    task automatic note_fault(input status_t code);
        if (fault_seen == ST_OK || code < fault_seen)
            fault_seen = code;
    endtask

    task automatic convert_char(input logic [CHAR_W-1:0] code, input logic lst,
                                input logic chk, input digit_res_t typed);
        logic [CHAR_W-1:0] c;
        logic [63:0]       d;
        logic [63:0]       v;
        logic [63:0]       r;
        logic [63:0]       radix_out;
        logic [63:0]       ceiling;
        bit                is_digit;
        digit_res_t        res;
        c = code;
        if (c >= ASCII_LA && c <= ASCII_LZ)
            c = c - CASE_GAP;
        is_digit = 1'b1;
        d = '0;
        if (c >= ASCII_0 && c <= ASCII_9)
            d = 64'(c - ASCII_0);
        else if (c >= ASCII_A && c <= ASCII_Z)
            d = 64'(c - ASCII_A + LETTER_OFS);
        else
            is_digit = 1'b0;

        if (!is_digit)
            note_fault(ST_CHAR);
        else if (d >= src_radix)
            note_fault(ST_BASE);
        else if (fault_seen == ST_OK)
        begin
            ceiling = (64'd1 << VALUE_BITS) - 64'd1;
            if (value_acc > (ceiling - d) / src_radix)
                note_fault(ST_OVF);
            else
                value_acc = value_acc * src_radix + d;
        end

        if (!lst)
            return;

        if (chk)
            pending_digits.push_back(typed);
        else if (fault_seen != ST_OK)
        begin
            res.code   = '0;
            res.eor    = 1'b1;
            res.status = fault_seen;
            pending_digits.push_back(res);
        end
        else
        begin
            radix_out = 64'(dst_radix);
            if (radix_out < TGT_BASE_MIN)
                radix_out = 64'(TGT_BASE_MIN);
            if (radix_out > TGT_BASE_MAX)
                radix_out = 64'(TGT_BASE_MAX);
            v = value_acc;
            do
            begin
                r = v % radix_out;
                v = v / radix_out;
                res.code   = (r < LETTER_OFS) ? ASCII_0 + r[7:0]
                                              : ASCII_A + r[7:0] - LETTER_OFS;
                res.eor    = (v == 64'd0);
                res.status = ST_OK;
                pending_digits.push_back(res);
            end
            while (v != 64'd0);
        end
        value_acc  = '0;
        fault_seen = ST_OK;
    endtask

    // valid stays high across back-to-back requests
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic lst,
                             input logic chk, input digit_res_t typed);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        convert_char(code, lst, chk, typed);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIGIT_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SOURCE_BASE)
            src_radix = value;
        else
            dst_radix = value;
    endtask

    function automatic logic [DIGIT_W-1:0] pick_radix();
        int roll;
        roll = $urandom_range(0, 11);
        if (roll == 0)
            return DIGIT_W'($urandom_range(0, 1));
        else if (roll == 1)
            return DIGIT_W'($urandom_range(37, 63));
        else if (roll == 2)
            return TGT_BASE_MIN;
        else if (roll == 3)
            return TGT_BASE_MAX;
        else
            return DIGIT_W'($urandom_range(2, 36));
    endfunction

    // mostly in-base digits; some long runs to overflow, some noisy numbers
    task automatic send_number();
        int                len;
        int                roll;
        int                span;
        int                dv;
        logic [CHAR_W-1:0] ch;
        roll = $urandom_range(0, 99);
        len  = (roll < 10) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        if (src_radix == 0)
            span = 1;
        else if (src_radix > TGT_BASE_MAX)
            span = int'(TGT_BASE_MAX);
        else
            span = int'(src_radix);
        for (int i = 0; i < len; i++)
        begin
            if (roll >= 80 && $urandom_range(0, 3) == 0)
                ch = CHAR_W'($urandom_range(0, 255));
            else
            begin
                dv = $urandom_range(0, span - 1);
                if (dv < LETTER_OFS)
                    ch = CHAR_W'(ASCII_0 + dv);
                else
                    ch = CHAR_W'(($urandom_range(0, 1) ? ASCII_A : ASCII_LA)
                                 + dv - LETTER_OFS);
            end
            send_char(ch, i == len - 1, 1'b0, '0);
        end
        random_sent += len;
    endtask

    initial
    begin
        digit_res_t typed;
        directed_rows = '{
            '{ROW_CHAR, 1'b0, ASCII_0,  1'b1, 1'b1, ASCII_0, 1'b1, ST_OK},
            '{ROW_CFG,  REG_SOURCE_BASE, 8'd36, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            // 1Z141Z3 in base 36 is the largest 32-bit value
            '{ROW_CHAR, 1'b0, "1",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "z",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "1",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "4",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "1",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "Z",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "3",      1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CFG,  REG_TARGET_BASE, 8'd63, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "Z",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "z",      1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CFG,  REG_TARGET_BASE, 8'd0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, 8'hFF,    1'b1, 1'b1, 8'h00, 1'b1, ST_CHAR},
            // seventh Z runs past 32 bits
            '{ROW_CHAR, 1'b0, "Z",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "Z",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "Z",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "Z",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "Z",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "Z",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "Z",      1'b1, 1'b1, 8'h00, 1'b1, ST_OVF},
            '{ROW_CFG,  REG_SOURCE_BASE, 8'd0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, ASCII_0,  1'b1, 1'b1, 8'h00, 1'b1, ST_BASE},
            '{ROW_CFG,  REG_SOURCE_BASE, 8'd1, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, ASCII_0,  1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, ASCII_0,  1'b1, 1'b1, ASCII_0, 1'b1, ST_OK},
            '{ROW_CFG,  REG_SOURCE_BASE, 8'd10, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            // digit out of base outranks a bad character
            '{ROW_CHAR, 1'b0, "a",      1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
            '{ROW_CHAR, 1'b0, "#",      1'b1, 1'b1, 8'h00, 1'b1, ST_BASE},
            '{ROW_CHAR, 1'b0, ASCII_9,  1'b1, 1'b0, 8'h00, 1'b0, ST_OK}
        };

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SOURCE_BASE;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        value_acc     = '0;
        fault_seen    = ST_OK;
        src_radix     = SRC_BASE_RST;
        dst_radix     = TGT_BASE_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].idx, directed_rows[i].val[DIGIT_W-1:0]);
            else
            begin
                typed.code   = directed_rows[i].x_code;
                typed.eor    = directed_rows[i].x_eor;
                typed.status = directed_rows[i].x_status;
                send_char(directed_rows[i].val, directed_rows[i].lst,
                          directed_rows[i].chk, typed);
            end
        end

        while (random_sent < RANDOM_CHARS)
        begin
            write_reg(REG_SOURCE_BASE, pick_radix());
            write_reg(REG_TARGET_BASE, pick_radix());
            if (random_sent == 0)
                hold_off_req = 1'b1;   // digit side blocks while requests pile up
            repeat ($urandom_range(3, 8)) send_number();
        end

        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // digit side: picks a new ready pattern when its random span runs out
    initial
    begin
        int mode;
        int span;
        int tick;
        m_axis_tready = 1'b0;
        mode = 0;
        span = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (tick % 4 == 0);
                    default: m_axis_tready <= (tick % 4 != 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_digits
        digit_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digits.size() == 0)
            begin
                $display("%0t unexpected digit: code %h last %b status %0d",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_digits.pop_front();
                if (m_axis_tdata !== want.code)
                begin
                    $display("%0t digit code: expected %h, got %h",
                             $time, want.code, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.eor)
                begin
                    $display("%0t end of run: expected %b, got %b",
                             $time, want.eor, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t status: expected %0d, got %0d",
                             $time, want.status, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t no request moved for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
